// ----- rtl/core/skwd_pkg.sv -----
// Shared types and codes for the session keepalive watchdog.
package skwd_pkg;

    localparam int unsigned IdWidth   = 64;
    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CntWidth  = 32;

    localparam logic [TimeWidth-1:0] TimeoutReset = TimeWidth'(3000);

    localparam logic OpFrame = 1'b0;
    localparam logic OpCheck = 1'b1;

    localparam logic [1:0] FrameStart = 2'd0;
    localparam logic [1:0] FrameStop  = 2'd1;
    localparam logic [1:0] FrameBeat  = 2'd2;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusInvalid = 2'd1;
    localparam logic [1:0] StatusDecode  = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic                 frame_ok;
        logic [1:0]           frame_type;
        logic [IdWidth-1:0]   frame_session;
        logic [IdWidth-1:0]   requested_session;
        logic [TimeWidth-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                expired;
        logic                session_open;
        logic [IdWidth-1:0]  open_session_id;
        logic [CntWidth-1:0] good_frames;
        logic [CntWidth-1:0] error_frames;
        logic [CntWidth-1:0] stale_frames;
    } result_t;

endpackage

// ----- rtl/core/session_keepalive_watchdog_unit.sv -----
// Top level of the session keepalive watchdog.
// An accepted transaction is held in the input stage register, and its result is held in the core's result register.
// Throughput: one transaction per cycle while out_ready does not stall the output; the session update is one pass
// of compare and add logic between the input and result registers.
// Reset: rst_n clears the session, all counters and both valid flags,
// and sets the timeout to 3000 ms.
module session_keepalive_watchdog_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skwd_pkg::TimeWidth-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic                          frame_ok,
    input  logic [1:0]                    frame_type,
    input  logic [skwd_pkg::IdWidth-1:0]  frame_session,
    input  logic [skwd_pkg::IdWidth-1:0]  requested_session,
    input  logic [skwd_pkg::TimeWidth-1:0] now_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic                          expired,
    output logic                          session_open,
    output logic [skwd_pkg::IdWidth-1:0]  open_session_id,
    output logic [skwd_pkg::CntWidth-1:0] good_frames,
    output logic [skwd_pkg::CntWidth-1:0] error_frames,
    output logic [skwd_pkg::CntWidth-1:0] stale_frames
);
    import skwd_pkg::*;

    logic [TimeWidth-1:0] timeout_reg;
    item_t                in_item;
    item_t                item;
    logic                 item_valid;
    logic                 item_take;
    result_t              result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TimeoutReset;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    assign in_item.opcode            = opcode;
    assign in_item.frame_ok          = frame_ok;
    assign in_item.frame_type        = frame_type;
    assign in_item.frame_session     = frame_session;
    assign in_item.requested_session = requested_session;
    assign in_item.now_ms            = now_ms;

    skwd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    skwd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .timeout    (timeout_reg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign status          = result.status;
    assign expired         = result.expired;
    assign session_open    = result.session_open;
    assign open_session_id = result.open_session_id;
    assign good_frames     = result.good_frames;
    assign error_frames    = result.error_frames;
    assign stale_frames    = result.stale_frames;

endmodule

// ----- rtl/core/skwd_in_stage.sv -----
// Input register stage that holds one accepted transaction for the core.
module skwd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skwd_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output skwd_pkg::item_t item
);
    import skwd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/core/skwd_core.sv -----
// Session state, counters, the timeout check and the result register.
module skwd_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [skwd_pkg::TimeWidth-1:0]     timeout,
    input  logic                               item_valid,
    output logic                               item_take,
    input  skwd_pkg::item_t                    item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output skwd_pkg::result_t                  result
);
    import skwd_pkg::*;

    logic                 active_reg;
    logic                 active_next;
    logic [IdWidth-1:0]   sess_reg;
    logic [IdWidth-1:0]   sess_next;
    logic [TimeWidth-1:0] beat_reg;
    logic [TimeWidth-1:0] beat_next;
    logic [CntWidth-1:0]  good_reg;
    logic [CntWidth-1:0]  good_next;
    logic [CntWidth-1:0]  error_reg;
    logic [CntWidth-1:0]  error_next;
    logic [CntWidth-1:0]  stale_reg;
    logic [CntWidth-1:0]  stale_next;
    logic                 valid_reg;
    logic [1:0]           status_next;
    logic                 expired_next;
    logic [TimeWidth-1:0] elapsed;
    logic                 sess_match;
    result_t              result_reg;

    assign item_take  = item_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign result     = result_reg;
    assign elapsed    = item.now_ms - beat_reg;
    assign sess_match = active_reg && (item.frame_session == sess_reg);

    always_comb
    begin
        active_next  = active_reg;
        sess_next    = sess_reg;
        beat_next    = beat_reg;
        good_next    = good_reg;
        error_next   = error_reg;
        stale_next   = stale_reg;
        status_next  = StatusOk;
        expired_next = 1'b0;
        if (item.opcode == OpCheck)
        begin
            if (active_reg && (elapsed > timeout))
            begin
                active_next  = 1'b0;
                sess_next    = '0;
                expired_next = 1'b1;
            end
        end
        else if (!item.frame_ok)
        begin
            error_next  = error_reg + 1'b1;
            status_next = StatusDecode;
        end
        else
        begin
            good_next = good_reg + 1'b1;
            case (item.frame_type)
                FrameStart:
                begin
                    if ((item.requested_session == '0) ||
                        (item.frame_session != item.requested_session))
                    begin
                        error_next  = error_reg + 1'b1;
                        status_next = StatusInvalid;
                    end
                    else
                    begin
                        sess_next   = item.requested_session;
                        active_next = 1'b1;
                        beat_next   = item.now_ms;
                    end
                end
                FrameStop:
                begin
                    if (!sess_match)
                    begin
                        stale_next  = stale_reg + 1'b1;
                        status_next = StatusInvalid;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        sess_next   = '0;
                    end
                end
                FrameBeat:
                begin
                    if (!sess_match)
                    begin
                        stale_next  = stale_reg + 1'b1;
                        status_next = StatusInvalid;
                    end
                    else
                    begin
                        beat_next = item.now_ms;
                    end
                end
                default:
                begin
                    error_next  = error_reg + 1'b1;
                    status_next = StatusInvalid;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sess_reg   <= '0;
            beat_reg   <= '0;
            good_reg   <= '0;
            error_reg  <= '0;
            stale_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                active_reg <= active_next;
                sess_reg   <= sess_next;
                beat_reg   <= beat_next;
                good_reg   <= good_next;
                error_reg  <= error_next;
                stale_reg  <= stale_next;
                valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            result_reg.status          <= status_next;
            result_reg.expired         <= expired_next;
            result_reg.session_open    <= active_next;
            result_reg.open_session_id <= sess_next;
            result_reg.good_frames     <= good_next;
            result_reg.error_frames    <= error_next;
            result_reg.stale_frames    <= stale_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the session keepalive watchdog with directed and random stimulus and idling.
`timescale 1ns / 100ps

module tb_top;
    import skwd_pkg::*;

    localparam logic [1:0] FrameOther = 2'd3;
    localparam int unsigned RunLimit = 400000;

    class watchdog_scoreboard;
        logic [TimeWidth-1:0] timeout_ms = TimeoutReset;
        logic                 is_open = 1'b0;
        logic [IdWidth-1:0]   open_id = '0;
        logic [TimeWidth-1:0] last_beat_ms = '0;
        logic [CntWidth-1:0]  good_cnt = '0;
        logic [CntWidth-1:0]  error_cnt = '0;
        logic [CntWidth-1:0]  stale_cnt = '0;
        result_t              pending_results[$];
        int unsigned          fault_count = 0;

        function void record_item(item_t it);
            result_t              want;
            logic [1:0]           st;
            logic                 closed_now;
            logic [TimeWidth-1:0] elapsed;
            st = StatusOk;
            closed_now = 1'b0;
            if (it.opcode == OpFrame)
            begin
                if (!it.frame_ok)
                begin
                    error_cnt++;
                    st = StatusDecode;
                end
                else
                begin
                    good_cnt++;
                    case (it.frame_type)
                        FrameStart:
                        begin
                            if (it.requested_session == '0 ||
                                it.frame_session != it.requested_session)
                            begin
                                error_cnt++;
                                st = StatusInvalid;
                            end
                            else
                            begin
                                open_id = it.requested_session;
                                is_open = 1'b1;
                                last_beat_ms = it.now_ms;
                            end
                        end
                        FrameStop, FrameBeat:
                        begin
                            if (!is_open || it.frame_session != open_id)
                            begin
                                stale_cnt++;
                                st = StatusInvalid;
                            end
                            else if (it.frame_type == FrameStop)
                            begin
                                is_open = 1'b0;
                                open_id = '0;
                            end
                            else
                            begin
                                last_beat_ms = it.now_ms;
                            end
                        end
                        default:
                        begin
                            error_cnt++;
                            st = StatusInvalid;
                        end
                    endcase
                end
            end
            else if (is_open)
            begin
                elapsed = it.now_ms - last_beat_ms;
                if (elapsed > timeout_ms)
                begin
                    is_open = 1'b0;
                    open_id = '0;
                    closed_now = 1'b1;
                end
            end
            want.status = st;
            want.expired = closed_now;
            want.session_open = is_open;
            want.open_session_id = open_id;
            want.good_frames = good_cnt;
            want.error_frames = error_cnt;
            want.stale_frames = stale_cnt;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                fault_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("A result arrived with no transaction outstanding.");
                fault_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("expired", 64'(want.expired), 64'(got.expired));
            compare_field("session_open", 64'(want.session_open), 64'(got.session_open));
            compare_field("open_session_id", want.open_session_id, got.open_session_id);
            compare_field("good_frames", 64'(want.good_frames), 64'(got.good_frames));
            compare_field("error_frames", 64'(want.error_frames), 64'(got.error_frames));
            compare_field("stale_frames", 64'(want.stale_frames), 64'(got.stale_frames));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TimeWidth-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic                 frame_ok;
    logic [1:0]           frame_type;
    logic [IdWidth-1:0]   frame_session;
    logic [IdWidth-1:0]   requested_session;
    logic [TimeWidth-1:0] now_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic                 expired;
    logic                 session_open;
    logic [IdWidth-1:0]   open_session_id;
    logic [CntWidth-1:0]  good_frames;
    logic [CntWidth-1:0]  error_frames;
    logic [CntWidth-1:0]  stale_frames;

    watchdog_scoreboard   sb = new;
    logic [TimeWidth-1:0] clock_ms = '0;
    logic [IdWidth-1:0]   id_pool[2];
    int unsigned          burst_left = 0;
    int unsigned          results_seen = 0;
    bit                   long_hold_done = 1'b0;

    session_keepalive_watchdog_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned sender_gap();
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            burst_left = 30;
            return 0;
        end
        return gap_len();
    endfunction

    function automatic logic [IdWidth-1:0] random_id();
        case ($urandom_range(0, 4))
            0: return '1;
            1: return 64'd1;
            2, 3: return id_pool[1'($urandom_range(0, 1))];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic item_t make_frame(logic op, logic ok, logic [1:0] ft,
                                         logic [IdWidth-1:0] fs, logic [IdWidth-1:0] rq,
                                         logic [TimeWidth-1:0] t);
        item_t it;
        it.opcode = op;
        it.frame_ok = ok;
        it.frame_type = ft;
        it.frame_session = fs;
        it.requested_session = rq;
        it.now_ms = t;
        return it;
    endfunction

    function automatic item_t make_item();
        item_t                it;
        int unsigned          pick;
        logic [TimeWidth-1:0] offset;
        pick = $urandom_range(0, 99);
        if (!sb.is_open && $urandom_range(0, 2) == 0)
            pick = 0;
        case ($urandom_range(0, 9))
            0: clock_ms = $urandom;
            1, 2: clock_ms = clock_ms + $urandom_range(0, 5000);
            default: clock_ms = clock_ms + $urandom_range(0, 30);
        endcase
        it = make_frame(OpFrame, 1'b1, FrameBeat, random_id(), random_id(), clock_ms);
        if (pick < 10)
        begin
            it.frame_type = FrameStart;
            it.requested_session = it.frame_session;
        end
        else if (pick < 18)
        begin
            it.frame_type = FrameStart;
            if ($urandom_range(0, 1))
            begin
                it.requested_session = '0;
                if ($urandom_range(0, 1))
                    it.frame_session = '0;
            end
            else
            begin
                it.requested_session = it.frame_session ^ (64'd1 << $urandom_range(0, 63));
            end
        end
        else if (pick < 58)
        begin
            it.frame_type = (pick < 48) ? FrameBeat : FrameStop;
            if (sb.is_open && $urandom_range(0, 7) != 0)
                it.frame_session = sb.open_id;
        end
        else if (pick < 63)
        begin
            it.frame_type = FrameOther;
        end
        else if (pick < 68)
        begin
            it.frame_ok = 1'b0;
            it.frame_type = 2'($urandom_range(0, 3));
        end
        else
        begin
            it.opcode = OpCheck;
            it.frame_ok = 1'($urandom_range(0, 1));
            it.frame_type = 2'($urandom_range(0, 3));
            if (sb.is_open && $urandom_range(0, 1))
            begin
                offset = $urandom_range(0, 2);
                it.now_ms = sb.last_beat_ms + sb.timeout_ms + offset - 1;
                clock_ms = it.now_ms;
            end
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= it.opcode;
        frame_ok <= it.frame_ok;
        frame_type <= it.frame_type;
        frame_session <= it.frame_session;
        requested_session <= it.requested_session;
        now_ms <= it.now_ms;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.record_item(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [TimeWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.timeout_ms = value;
    endtask

    task automatic run_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_item(make_item());
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin : stimulus
        item_t                plan[$];
        logic [TimeWidth-1:0] timeout_plan[5];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OpFrame;
        frame_ok = 1'b0;
        frame_type = FrameStart;
        frame_session = '0;
        requested_session = '0;
        now_ms = '0;
        id_pool[0] = {$urandom, $urandom};
        id_pool[1] = {$urandom, $urandom};
        timeout_plan[0] = 32'd1;
        timeout_plan[1] = 32'hFFFF_FFFF;
        timeout_plan[2] = $urandom_range(2, 100);
        timeout_plan[3] = $urandom;
        timeout_plan[4] = $urandom_range(500, 5000);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        plan.push_back(make_frame(OpCheck, 1'b0, FrameStart, '0, '0, 32'd0));
        plan.push_back(make_frame(OpFrame, 1'b0, FrameOther, '1, '1, '1));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, '0, '0, 32'd10));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, 64'd6, 64'd5, 32'd20));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, '1, '1, 32'd100));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameBeat, '1, '0, 32'd3000));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameBeat, ~64'd1, '0, 32'd3001));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStop, 64'd1, '0, 32'd3002));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameOther, '1, '1, 32'd3003));
        plan.push_back(make_frame(OpCheck, 1'b1, FrameStop, '1, '0, 32'd6000));
        plan.push_back(make_frame(OpCheck, 1'b0, FrameStart, '0, '0, 32'd6001));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStop, '0, '0, 32'd6002));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameBeat, '0, '0, 32'd6003));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, 64'd1, 64'd1, 32'hFFFF_FF00));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, 64'd2, 64'd2, 32'hFFFF_FFF0));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameBeat, 64'd1, '0, 32'hFFFF_FFF1));
        plan.push_back(make_frame(OpCheck, 1'b1, FrameBeat, 64'd2, 64'd2, 32'h0000_0BA0));
        plan.push_back(make_frame(OpCheck, 1'b0, FrameStart, '0, '0, 32'h0000_0BA9));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStart, 64'd7, 64'd7, 32'h100));
        plan.push_back(make_frame(OpFrame, 1'b1, FrameStop, 64'd7, 64'd7, 32'h200));
        plan.push_back(make_frame(OpCheck, 1'b1, FrameStart, 64'd7, 64'd7, 32'h8000_0000));
        plan.push_back(make_frame(OpFrame, 1'b0, FrameStart, 64'd8, 64'd8, 32'd0));
        foreach (plan[i])
            send_item(plan[i]);
        drain_results();

        run_random(100);
        foreach (timeout_plan[p])
        begin
            drain_results();
            write_timeout(timeout_plan[p]);
            run_random(100);
        end
        drain_results();

        if (sb.fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : receiver
        int unsigned gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= 40)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            gap = gap_len();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status = status;
            got.expired = expired;
            got.session_open = session_open;
            got.open_session_id = open_session_id;
            got.good_frames = good_frames;
            got.error_frames = error_frames;
            got.stale_frames = stale_frames;
            sb.check_result(got);
            results_seen++;
        end
    end

    initial
    begin : run_limit
        int unsigned cycles;
        cycles = 0;
        while (cycles < RunLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
